// ===== hw/rtl/dwis_pkg.sv =====
package dwis_pkg;

    // operation codes on the input tuser
    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_CLEAR      = 3'd4;
    localparam logic [2:0] OP_LIST_FWD   = 3'd5;
    localparam logic [2:0] OP_LIST_REV   = 3'd6;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_ID_START = 2'd0;
    localparam logic [1:0] CFG_ID_STEP  = 2'd1;
    localparam logic [1:0] CFG_MIN_ID   = 2'd2;

    localparam logic [31:0] ID_START_RST = 32'd10;
    localparam logic [31:0] ID_STEP_RST  = 32'd10;
    localparam logic [31:0] MIN_ID_RST   = 32'd0;

    typedef enum logic [2:0] {
        K_PUSH_FRONT,
        K_PUSH_BACK,
        K_POP_FRONT,
        K_POP_BACK,
        K_CLEAR,
        K_LIST_FWD,
        K_LIST_REV,
        K_NOP
    } t_kind;

    typedef enum logic [1:0] {
        B_IDLE,
        B_RD,
        B_CHK,
        B_FINAL
    } t_bstate;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] cost;
        logic [31:0] sale;
        logic        cat;
    } t_cmd;

    typedef struct packed {
        logic        valid;
        t_cmd        cmd;
    } t_cmd_head;

    typedef struct packed {
        logic        we;
        logic [1:0]  idx;
        logic [31:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic [31:0] id;
        logic [31:0] cost;
        logic [31:0] sale;
        logic        cat;
    } t_rec;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] id;
        logic [31:0] cost;
        logic [31:0] sale;
        logic        cat;
        logic [4:0]  count;
        logic        last;
        logic        full;
    } t_res;

endpackage

// ===== hw/rtl/dwis_ram.sv =====
module dwis_ram #(
    parameter int WIDTH = 97,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/dwis_front.sv =====
module dwis_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [2:0]          i_op,
    input  logic [31:0]         i_cost,
    input  logic [31:0]         i_sale,
    input  logic                i_cat,
    output dwis_pkg::t_cmd_head o_head,
    input  logic                i_pop
);

    import dwis_pkg::*;

    localparam logic [1:0] Q_FULL = 2'd2;

    t_cmd       r_q [2];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    t_cmd       w_cmd;
    logic       w_push;

    // classify the operation code
    always_comb begin
        w_cmd.cost = i_cost;
        w_cmd.sale = i_sale;
        w_cmd.cat  = i_cat;
        case (i_op)
            OP_PUSH_FRONT: w_cmd.kind = K_PUSH_FRONT;
            OP_PUSH_BACK:  w_cmd.kind = K_PUSH_BACK;
            OP_POP_FRONT:  w_cmd.kind = K_POP_FRONT;
            OP_POP_BACK:   w_cmd.kind = K_POP_BACK;
            OP_CLEAR:      w_cmd.kind = K_CLEAR;
            OP_LIST_FWD:   w_cmd.kind = K_LIST_FWD;
            OP_LIST_REV:   w_cmd.kind = K_LIST_REV;
            default:       w_cmd.kind = K_NOP;
        endcase
    end

    assign o_s_tready = (r_cnt != Q_FULL);
    assign w_push     = i_s_tvalid && o_s_tready;

    always_comb begin
        n_wp  = w_push ? ~r_wp : r_wp;
        n_rp  = i_pop ? ~r_rp : r_rp;
        n_cnt = r_cnt;
        if (w_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!w_push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.cmd   = r_q[r_rp];

endmodule

// ===== hw/rtl/dwis_back.sv =====
module dwis_back #(
    parameter int DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dwis_pkg::t_cfg_wr   i_cfg,
    input  dwis_pkg::t_cmd_head i_head,
    output logic                o_pop,
    output logic                o_res_valid,
    output dwis_pkg::t_res      o_res,
    input  logic                i_res_ready
);

    import dwis_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int OW = $clog2(DEPTH + 1);
    localparam logic [IW:0]   DEPTH_W = (IW + 1)'(DEPTH);
    localparam logic [OW-1:0] DEPTH_O = OW'(DEPTH);
    localparam logic [IW-1:0] LAST_SLOT = IW'(DEPTH - 1);

    t_bstate       r_state, n_state;
    logic [IW-1:0] r_front, n_front;
    logic [OW-1:0] r_occ, n_occ;
    logic [31:0]   r_next_id, n_next_id;
    logic [31:0]   r_id_step;
    logic [31:0]   r_min_id;
    logic [OW-1:0] r_pos, n_pos;
    logic [4:0]    r_cnt, n_cnt;
    logic          r_rev, n_rev;
    logic          r_out_valid, n_out_valid;
    t_res          r_out, n_out;

    logic          w_out_free;
    logic          w_full;
    logic          w_empty;
    logic          w_match;
    logic          w_is_list;
    logic [OW-1:0] w_list_pos;
    logic [IW:0]   w_list_sum;
    logic [IW:0]   w_back_sum;
    logic [IW-1:0] w_front_dec;
    logic [IW-1:0] w_front_inc;
    logic [IW-1:0] w_back_slot;
    logic          w_we;
    logic [IW-1:0] w_waddr;
    t_rec          w_wdata;
    logic [IW-1:0] w_raddr;
    t_rec          w_rdata;

    dwis_ram #(
        .WIDTH($bits(t_rec)),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign w_out_free = !r_out_valid || i_res_ready;
    assign w_full     = (r_occ == DEPTH_O);
    assign w_empty    = (r_occ == '0);
    assign w_match    = (w_rdata.id > r_min_id);
    assign w_is_list  = (i_head.cmd.kind == K_LIST_FWD) || (i_head.cmd.kind == K_LIST_REV);

    // ring slot arithmetic
    assign w_front_dec = (r_front == '0) ? LAST_SLOT : r_front - IW'(1);
    assign w_front_inc = (r_front == LAST_SLOT) ? '0 : r_front + IW'(1);
    assign w_back_sum  = {1'b0, r_front} + {1'b0, r_occ[IW-1:0]};
    assign w_back_slot = (w_back_sum >= DEPTH_W) ? IW'(w_back_sum - DEPTH_W)
                                                 : w_back_sum[IW-1:0];
    assign w_list_pos  = r_rev ? (r_occ - OW'(1) - r_pos) : r_pos;
    assign w_list_sum  = {1'b0, r_front} + {1'b0, w_list_pos[IW-1:0]};
    assign w_raddr     = (w_list_sum >= DEPTH_W) ? IW'(w_list_sum - DEPTH_W)
                                                 : w_list_sum[IW-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (i_head.valid && w_out_free && w_is_list) begin
                    n_state = B_RD;
                end
            end
            B_RD: begin
                n_state = (r_pos == r_occ) ? B_FINAL : B_CHK;
            end
            B_CHK: begin
                if (!w_match || w_out_free) begin
                    n_state = B_RD;
                end
            end
            B_FINAL: begin
                if (w_out_free) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        t_res res;
        logic load;
        res         = '0;
        res.full    = w_full;
        load        = 1'b0;
        o_pop       = 1'b0;
        w_we        = 1'b0;
        w_waddr     = w_front_dec;
        w_wdata     = '{id: r_next_id, cost: i_head.cmd.cost, sale: i_head.cmd.sale,
                        cat: i_head.cmd.cat};
        n_front     = r_front;
        n_occ       = r_occ;
        n_next_id   = r_next_id;
        n_pos       = r_pos;
        n_cnt       = r_cnt;
        n_rev       = r_rev;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_res_ready;
        case (r_state)
            B_IDLE: begin
                if (i_head.valid && w_out_free) begin
                    o_pop    = 1'b1;
                    load     = !w_is_list;
                    res.last = 1'b1;
                    case (i_head.cmd.kind)
                        K_PUSH_FRONT, K_PUSH_BACK: begin
                            if (w_full) begin
                                res.status = ST_FULL;
                            end else begin
                                w_we      = 1'b1;
                                n_occ     = r_occ + OW'(1);
                                n_next_id = r_next_id + r_id_step;
                                res.id    = r_next_id;
                                res.full  = (n_occ == DEPTH_O);
                                if (i_head.cmd.kind == K_PUSH_FRONT) begin
                                    n_front = w_front_dec;
                                end else begin
                                    w_waddr = w_back_slot;
                                end
                            end
                        end
                        K_POP_FRONT, K_POP_BACK: begin
                            if (w_empty) begin
                                res.status = ST_EMPTY;
                            end else begin
                                n_occ    = r_occ - OW'(1);
                                res.full = 1'b0;
                                if (i_head.cmd.kind == K_POP_FRONT) begin
                                    n_front = w_front_inc;
                                end
                            end
                        end
                        K_CLEAR: begin
                            n_front  = '0;
                            n_occ    = '0;
                            res.full = 1'b0;
                        end
                        K_LIST_FWD, K_LIST_REV: begin
                            n_pos = '0;
                            n_cnt = '0;
                            n_rev = (i_head.cmd.kind == K_LIST_REV);
                        end
                        default: begin
                        end
                    endcase
                end
            end
            B_CHK: begin
                if (!w_match) begin
                    n_pos = r_pos + OW'(1);
                end else if (w_out_free) begin
                    load     = 1'b1;
                    res.id   = w_rdata.id;
                    res.cost = w_rdata.cost;
                    res.sale = w_rdata.sale;
                    res.cat  = w_rdata.cat;
                    n_pos    = r_pos + OW'(1);
                    n_cnt    = r_cnt + 5'd1;
                end
            end
            B_FINAL: begin
                if (w_out_free) begin
                    load      = 1'b1;
                    res.count = r_cnt;
                    res.last  = 1'b1;
                end
            end
            default: begin
            end
        endcase
        // a write to id_start reloads the next id
        if (i_cfg.we && (i_cfg.idx == CFG_ID_START)) begin
            n_next_id = i_cfg.data;
        end
        if (load) begin
            n_out       = res;
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_front     <= '0;
            r_occ       <= '0;
            r_next_id   <= ID_START_RST;
            r_id_step   <= ID_STEP_RST;
            r_min_id    <= MIN_ID_RST;
            r_pos       <= '0;
            r_cnt       <= '0;
            r_rev       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_occ       <= n_occ;
            r_next_id   <= n_next_id;
            r_pos       <= n_pos;
            r_cnt       <= n_cnt;
            r_rev       <= n_rev;
            r_out_valid <= n_out_valid;
            if (i_cfg.we) begin
                case (i_cfg.idx)
                    CFG_ID_STEP:  r_id_step <= i_cfg.data;
                    CFG_MIN_ID:   r_min_id  <= i_cfg.data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

// ===== hw/rtl/deque_with_id_stamping.sv =====
// bounded double-ended queue of records with id stamping, kept in a ring buffer
// input stream: one beat per operation, tuser carries the operation code,
//   tdata the record to push (ignored by other operations)
// output stream: one beat per result, tlast marks the final result of an operation
// config port: write enable, register index and data, taken at any edge with we high; the user
//   must write only while the block is idle (not enforced); writing id_start also reloads the next id
// a two-entry command queue parts the accepting front from the executing back
// a result passes through the command queue and then the output register before it shows
// push, pop and clear run back to back, so one beat per cycle when the receiver keeps tready
//   high and no list is in progress
// a list takes the command, then spends a ram read state and a compare state on each
//   stored record, then a read state that sees the end of the walk and a final state
//   that sends the count beat
// reset (synchronous, active low) empties the queue, loads the next id with 10
//   and restores the register defaults; the record ram is not cleared
// a stalled receiver holds the output register; the back then stops and the
//   command queue fills, after which tready on the input drops
module deque_with_id_stamping #(
    parameter int DEPTH = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input stream
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [71:0]  i_s_tdata,   // cost_bits[31:0], sale_bits[63:32], in_catalog[64], zero
    input  logic [2:0]   i_s_tuser,   // operation[2:0]
    // output stream
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [111:0] o_m_tdata,   // status[1:0], entry_id[33:2], entry_cost[65:34],
                                      // entry_sale[97:66], entry_catalog[98],
                                      // match_count[103:99], now_full[104], zero
    output logic         o_m_tlast,   // is_last
    // configuration writes
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_data
);

    import dwis_pkg::*;

    t_cmd_head w_head;
    logic      w_pop;
    t_cfg_wr   w_cfg;
    logic      w_res_valid;
    t_res      w_res;

    // front: accepts beats, decodes the operation, queues commands
    dwis_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_op      (i_s_tuser),
        .i_cost    (i_s_tdata[31:0]),
        .i_sale    (i_s_tdata[63:32]),
        .i_cat     (i_s_tdata[64]),
        .o_head    (w_head),
        .i_pop     (w_pop)
    );

    assign w_cfg.we   = i_cfg_we;
    assign w_cfg.idx  = i_cfg_idx;
    assign w_cfg.data = i_cfg_data;

    // back: ring state, record ram, list walk and output register
    dwis_back #(
        .DEPTH(DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_head     (w_head),
        .o_pop      (w_pop),
        .o_res_valid(w_res_valid),
        .o_res      (w_res),
        .i_res_ready(i_m_tready)
    );

    assign o_m_tvalid = w_res_valid;
    assign o_m_tlast  = w_res.last;
    assign o_m_tdata  = {7'd0, w_res.full, w_res.count, w_res.cat, w_res.sale,
                         w_res.cost, w_res.id, w_res.status};

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import dwis_pkg::*;

    localparam int QDEPTH           = 16;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int SHOWN_MISMATCHES = 10;
    // idle time after draining, enough to cover the tail of a list of a full queue
    localparam int DRAIN_CYCLES     = 40;
    localparam int RESET_CYCLES     = 7;
    localparam int PHASE_ITEMS      = 76;

    // codes the package leaves unnamed: the spare operation and the spare register index
    localparam logic [2:0] OP_UNUSED  = 3'd7;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    logic         i_clk      = 1'b0;
    logic         i_rst_n    = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [71:0]  i_s_tdata  = '0;   // cost_bits[31:0], sale_bits[63:32], in_catalog[64], zero
    logic [2:0]   i_s_tuser  = '0;   // operation[2:0]
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [111:0] o_m_tdata;         // status[1:0], entry_id[33:2], entry_cost[65:34],
                                     // entry_sale[97:66], entry_catalog[98],
                                     // match_count[103:99], now_full[104], zero
    logic         o_m_tlast;         // is_last
    logic         i_cfg_we   = 1'b0;
    logic [1:0]   i_cfg_idx  = '0;
    logic [31:0]  i_cfg_data = '0;

    int send_idle_pct = 21;
    int recv_idle_pct = 54;
    int mismatches    = 0;
    int cycle_count   = 0;

    // shadow copy of the deque: ring of records, front slot and fill level
    logic [31:0] shadow_id   [QDEPTH];
    logic [31:0] shadow_cost [QDEPTH];
    logic [31:0] shadow_sale [QDEPTH];
    logic        shadow_cat  [QDEPTH];
    int          shadow_front   = 0;
    int          shadow_occ     = 0;
    logic [31:0] shadow_next_id = ID_START_RST;

    // shadow copy of the registers
    logic [31:0] reg_id_start = ID_START_RST;
    logic [31:0] reg_id_step  = ID_STEP_RST;
    logic [31:0] reg_min_id   = MIN_ID_RST;

    // result beats still owed by the block, oldest first
    t_res pending_results [$];

    deque_with_id_stamping #(
        .DEPTH (QDEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // now_full always reflects the fill level after the operation
    function automatic t_res make_result(input logic [1:0] status, input logic [31:0] id,
                                         input logic [31:0] cost, input logic [31:0] sale,
                                         input logic cat, input logic [4:0] count,
                                         input logic last);
        t_res r;
        r.status = status;
        r.id     = id;
        r.cost   = cost;
        r.sale   = sale;
        r.cat    = cat;
        r.count  = count;
        r.last   = last;
        r.full   = (shadow_occ >= QDEPTH);
        return r;
    endfunction

    // apply one accepted operation to the shadow deque and queue up its result beats
    function automatic void apply_deque_op(input logic [2:0] op, input logic [31:0] cost,
                                           input logic [31:0] sale, input logic cat);
        int slot;
        int pos;
        int hits;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (shadow_occ >= QDEPTH) begin
                    // rejected: nothing stored, id counter untouched
                    pending_results.push_back(make_result(ST_FULL, '0, '0, '0, 1'b0, '0, 1'b1));
                end else begin
                    if (op == OP_PUSH_FRONT) begin
                        shadow_front = (shadow_front + QDEPTH - 1) % QDEPTH;
                        slot = shadow_front;
                    end else begin
                        slot = (shadow_front + shadow_occ) % QDEPTH;
                    end
                    shadow_id[slot]   = shadow_next_id;
                    shadow_cost[slot] = cost;
                    shadow_sale[slot] = sale;
                    shadow_cat[slot]  = cat;
                    shadow_occ++;
                    pending_results.push_back(make_result(ST_OK, shadow_next_id, '0, '0, 1'b0,
                                                          '0, 1'b1));
                    shadow_next_id = shadow_next_id + reg_id_step;
                end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
                if (shadow_occ == 0) begin
                    pending_results.push_back(make_result(ST_EMPTY, '0, '0, '0, 1'b0, '0, 1'b1));
                end else begin
                    if (op == OP_POP_FRONT)
                        shadow_front = (shadow_front + 1) % QDEPTH;
                    shadow_occ--;
                    pending_results.push_back(make_result(ST_OK, '0, '0, '0, 1'b0, '0, 1'b1));
                end
            end
            OP_CLEAR: begin
                shadow_front = 0;
                shadow_occ   = 0;
                pending_results.push_back(make_result(ST_OK, '0, '0, '0, 1'b0, '0, 1'b1));
            end
            OP_LIST_FWD, OP_LIST_REV: begin
                hits = 0;
                for (int i = 0; i < shadow_occ; i++) begin
                    pos  = (op == OP_LIST_FWD) ? i : (shadow_occ - 1 - i);
                    slot = (shadow_front + pos) % QDEPTH;
                    // strictly above the threshold, unsigned
                    if (shadow_id[slot] > reg_min_id) begin
                        pending_results.push_back(make_result(ST_OK, shadow_id[slot],
                                                              shadow_cost[slot],
                                                              shadow_sale[slot],
                                                              shadow_cat[slot], '0, 1'b0));
                        hits++;
                    end
                end
                // closing beat carries the count only
                pending_results.push_back(make_result(ST_OK, '0, '0, '0, 1'b0, 5'(hits), 1'b1));
            end
            default: begin
                // spare operation code does nothing but answer
                pending_results.push_back(make_result(ST_OK, '0, '0, '0, 1'b0, '0, 1'b1));
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // result side: random backpressure and checking
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_m_tready <= 1'b0;
        else
            i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic string fmt_res(input t_res r);
        return $sformatf("st=%0d id=%h cost=%h sale=%h cat=%0d cnt=%0d last=%0d full=%0d",
                         r.status, r.id, r.cost, r.sale, r.cat, r.count, r.last, r.full);
    endfunction

    function automatic void flag_mismatch(input string why, input t_res want, input t_res seen);
        mismatches++;
        if (mismatches <= SHOWN_MISMATCHES) begin
            $display("mismatch (%s) at cycle %0d", why, cycle_count);
            $display("  expected %s", fmt_res(want));
            $display("  actual   %s", fmt_res(seen));
        end
    endfunction

    // values are read at the edge, before any of this edge's updates land
    always @(posedge i_clk) begin : result_check
        t_res seen;
        t_res want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            seen.status = o_m_tdata[1:0];
            seen.id     = o_m_tdata[33:2];
            seen.cost   = o_m_tdata[65:34];
            seen.sale   = o_m_tdata[97:66];
            seen.cat    = o_m_tdata[98];
            seen.count  = o_m_tdata[103:99];
            seen.full   = o_m_tdata[104];
            seen.last   = o_m_tlast;
            if (pending_results.size() == 0) begin
                flag_mismatch("beat with nothing owed", '0, seen);
            end else begin
                want = pending_results.pop_front();
                if (seen !== want)
                    flag_mismatch("wrong field", want, seen);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[deque_with_id_stamping] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers, all entered and left on a rising edge
    // ------------------------------------------------------------------

    // one operation beat; tvalid is only lowered when a gap is actually taken
    task automatic send_beat(input logic [2:0] op, input logic [31:0] cost,
                             input logic [31:0] sale, input logic cat);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {7'd0, cat, sale, cost};
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        apply_deque_op(op, cost, sale, cat);
    endtask

    // mostly random words, with the all-zero and all-one patterns mixed in
    function automatic logic [31:0] pick_word();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return 32'h0000_0000;
        else if (r == 1)
            return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    task automatic send_record(input logic [2:0] op);
        send_beat(op, pick_word(), pick_word(), 1'($urandom_range(1)));
    endtask

    // stop sending and let every owed beat come back, plus the block's tail
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // only called with the block drained; we drops again before any next write
    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_ID_START: begin
                reg_id_start   = value;
                shadow_next_id = value;
            end
            CFG_ID_STEP: reg_id_step = value;
            CFG_MIN_ID:  reg_min_id  = value;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    function automatic logic [2:0] pick_op();
        int r;
        r = $urandom_range(99);
        if (r < 21)      return OP_PUSH_FRONT;
        else if (r < 42) return OP_PUSH_BACK;
        else if (r < 56) return OP_POP_FRONT;
        else if (r < 70) return OP_POP_BACK;
        else if (r < 83) return OP_LIST_FWD;
        else if (r < 95) return OP_LIST_REV;
        else if (r < 98) return OP_CLEAR;
        return OP_UNUSED;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // every removal and listing on an empty queue, and the spare code
    task automatic test_empty_queue();
        send_record(OP_POP_FRONT);
        send_record(OP_POP_BACK);
        send_record(OP_LIST_REV);
        send_record(OP_LIST_FWD);
        send_record(OP_UNUSED);
    endtask

    // both ends, extreme record fields, both walk directions, clear
    task automatic test_ends_and_listing();
        send_beat(OP_PUSH_FRONT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_beat(OP_PUSH_BACK,  32'h0000_0000, 32'h0000_0000, 1'b0);
        send_beat(OP_PUSH_FRONT, 32'hAAAA_5555, 32'h5555_AAAA, 1'b0);
        send_beat(OP_PUSH_BACK,  32'h5555_AAAA, 32'hAAAA_5555, 1'b1);
        send_record(OP_LIST_FWD);
        send_record(OP_LIST_REV);
        send_record(OP_POP_BACK);
        send_record(OP_POP_FRONT);
        send_record(OP_UNUSED);
        send_record(OP_CLEAR);
        send_record(OP_LIST_FWD);
    endtask

    // id wrap, threshold extremes, zero and all-ones step, spare register index
    task automatic test_id_config();
        wait_drained();
        cfg_write(CFG_ID_START, 32'hFFFF_FFF8);
        cfg_write(CFG_ID_STEP, 32'd4);
        send_record(OP_PUSH_BACK);
        send_record(OP_PUSH_BACK);
        send_record(OP_PUSH_FRONT);       // stamped id wraps to zero
        wait_drained();
        cfg_write(CFG_MIN_ID, 32'hFFFF_FFFF);
        send_record(OP_LIST_FWD);         // nothing can be above the top
        wait_drained();
        cfg_write(CFG_MIN_ID, 32'h0000_0000);
        cfg_write(CFG_ID_STEP, 32'h0000_0000);
        cfg_write(CFG_UNUSED, 32'hFFFF_FFFF);
        send_record(OP_LIST_REV);         // the zero id is left out
        send_record(OP_PUSH_FRONT);
        send_record(OP_PUSH_BACK);        // same id again with zero step
        wait_drained();
        cfg_write(CFG_ID_STEP, 32'hFFFF_FFFF);
        send_record(OP_PUSH_BACK);
        send_record(OP_PUSH_BACK);        // step of minus one counts down
        send_record(OP_LIST_FWD);
        send_record(OP_CLEAR);
    endtask

    // fill to the brim, rejected pushes at both ends, longest listings
    task automatic test_full_queue();
        wait_drained();
        cfg_write(CFG_ID_START, 32'd1);
        cfg_write(CFG_ID_STEP, 32'd1);
        for (int i = 0; i < QDEPTH; i++)
            send_record((i % 2 == 0) ? OP_PUSH_BACK : OP_PUSH_FRONT);
        send_record(OP_PUSH_FRONT);
        send_record(OP_PUSH_BACK);
        send_record(OP_LIST_FWD);
        send_record(OP_LIST_REV);
        send_record(OP_POP_FRONT);
        send_record(OP_PUSH_BACK);        // full again across the wrap
        send_record(OP_LIST_FWD);
        // hold off until every owed beat is back, then carry on
        wait_drained();
        send_record(OP_POP_BACK);
        send_record(OP_CLEAR);
    endtask

    task automatic run_random_ops(input int n_items);
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(99) < 2)
                wait_drained();
            send_record(pick_op());
        end
    endtask

    // three idle patterns, each with its own register setting
    task automatic test_random_traffic();
        logic [31:0] start_id;
        logic [31:0] step_id;

        // ids rise gently, the first few stamped stay under the threshold
        wait_drained();
        start_id = $urandom;
        step_id  = $urandom_range(1, 1000);
        cfg_write(CFG_ID_START, start_id);
        cfg_write(CFG_ID_STEP, step_id);
        cfg_write(CFG_MIN_ID, start_id + step_id * 4);
        run_random_ops(PHASE_ITEMS);

        // sender and receiver swap idle rates, fully random ids
        wait_drained();
        send_idle_pct = 54;
        recv_idle_pct = 21;
        cfg_write(CFG_ID_START, $urandom);
        cfg_write(CFG_ID_STEP, $urandom);
        cfg_write(CFG_MIN_ID, $urandom);
        run_random_ops(PHASE_ITEMS);

        // back to back, ids wrap through the top of the range
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        cfg_write(CFG_ID_START, 32'hFFFF_FF00);
        cfg_write(CFG_ID_STEP, 32'h0000_0011);
        cfg_write(CFG_MIN_ID, 32'h8000_0000);
        run_random_ops(PHASE_ITEMS);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_queue();
        test_ends_and_listing();
        test_id_config();
        test_full_queue();
        test_random_traffic();

        wait_drained();
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("[deque_with_id_stamping] OK");
        end else begin
            $display("[deque_with_id_stamping] ERROR");
        end
        $finish;
    end

endmodule
